### design/color_blend_unit_defines.svh
// Assertion helpers for the color blend unit.
`ifndef COLOR_BLEND_UNIT_DEFINES_SVH
`define COLOR_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CBU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CBU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cbu_pkg.sv
package cbu_pkg;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int PROD_W     = 2 * CH_W;
	localparam int EQ_W       = 3;
	localparam int FACTOR_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Channel order inside a vector: 0 red, 1 green, 2 blue, 3 alpha
	localparam int ALPHA_CH = 3;

	typedef logic [NUM_CH-1:0][CH_W-1:0]   chan_vec_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_vec_t;

	// Blend equations; codes above EQ_MAX act as add
	localparam logic [EQ_W-1:0] EQ_ADD  = 3'd0;
	localparam logic [EQ_W-1:0] EQ_SUB  = 3'd1;
	localparam logic [EQ_W-1:0] EQ_RSUB = 3'd2;
	localparam logic [EQ_W-1:0] EQ_MIN  = 3'd3;
	localparam logic [EQ_W-1:0] EQ_MAX  = 3'd4;

	// Blend factors; unused codes select zero
	localparam logic [FACTOR_W-1:0] F_ZERO          = 4'd0;
	localparam logic [FACTOR_W-1:0] F_ONE           = 4'd1;
	localparam logic [FACTOR_W-1:0] F_SRC_COLOR     = 4'd2;
	localparam logic [FACTOR_W-1:0] F_DST_COLOR     = 4'd3;
	localparam logic [FACTOR_W-1:0] F_SRC_ALPHA     = 4'd4;
	localparam logic [FACTOR_W-1:0] F_DST_ALPHA     = 4'd5;
	localparam logic [FACTOR_W-1:0] F_INV_SRC_COLOR = 4'd6;
	localparam logic [FACTOR_W-1:0] F_INV_DST_COLOR = 4'd7;
	localparam logic [FACTOR_W-1:0] F_INV_SRC_ALPHA = 4'd8;
	localparam logic [FACTOR_W-1:0] F_INV_DST_ALPHA = 4'd9;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EQUATION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FACTOR = 2'd2;

	localparam logic [CH_W-1:0] UNORM_ONE = 8'hFF;

	typedef struct packed {
		logic [CH_W-1:0] src_red;
		logic [CH_W-1:0] src_green;
		logic [CH_W-1:0] src_blue;
		logic [CH_W-1:0] src_alpha;
		logic [CH_W-1:0] dst_red;
		logic [CH_W-1:0] dst_green;
		logic [CH_W-1:0] dst_blue;
		logic [CH_W-1:0] dst_alpha;
	} cbu_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} cbu_out_t;

	typedef struct packed {
		logic [EQ_W-1:0]     equation;
		logic [FACTOR_W-1:0] src_factor;
		logic [FACTOR_W-1:0] dst_factor;
	} cbu_cfg_t;

	// Occupancy of the multiply stages
	typedef struct packed {
		logic valid_s2;
		logic valid_s3;
	} cbu_occ_t;

	// Factor for one channel
	function automatic logic [CH_W-1:0] pick_factor(
		input logic [FACTOR_W-1:0] code,
		input logic [CH_W-1:0]     s_ch,
		input logic [CH_W-1:0]     s_a,
		input logic [CH_W-1:0]     d_ch,
		input logic [CH_W-1:0]     d_a
	);
		logic [CH_W-1:0] f;
		case (code)
			F_ONE:           f = UNORM_ONE;
			F_SRC_COLOR:     f = s_ch;
			F_DST_COLOR:     f = d_ch;
			F_SRC_ALPHA:     f = s_a;
			F_DST_ALPHA:     f = d_a;
			F_INV_SRC_COLOR: f = UNORM_ONE - s_ch;
			F_INV_DST_COLOR: f = UNORM_ONE - d_ch;
			F_INV_SRC_ALPHA: f = UNORM_ONE - s_a;
			F_INV_DST_ALPHA: f = UNORM_ONE - d_a;
			default:         f = '0;
		endcase
		return f;
	endfunction

	// Round-to-nearest product / 255: y = p + 127, then y / 255 as
	// (y + (y >> 8) + 1) >> 8, exact for y below 65535.
	function automatic logic [CH_W-1:0] div255_round(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] y;
		logic [PROD_W:0] q;
		y = {1'b0, p} + (PROD_W+1)'(127);
		q = y + (y >> CH_W) + (PROD_W+1)'(1);
		return q[PROD_W-1:CH_W];
	endfunction

endpackage

### design/cbu_factor_stage.sv
module cbu_factor_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  cbu_pkg::cbu_in_t pix,
	input  cbu_pkg::cbu_cfg_t cfg,
	output logic             valid_s1,
	input  logic             ready_s1,
	output cbu_pkg::chan_vec_t src_s1,
	output cbu_pkg::chan_vec_t dst_s1,
	output cbu_pkg::chan_vec_t fs_s1,
	output cbu_pkg::chan_vec_t fd_s1
);
	import cbu_pkg::*;

	chan_vec_t s_vec;
	chan_vec_t d_vec;
	chan_vec_t fs_vec;
	chan_vec_t fd_vec;

	assign s_vec = {pix.src_alpha, pix.src_blue, pix.src_green, pix.src_red};
	assign d_vec = {pix.dst_alpha, pix.dst_blue, pix.dst_green, pix.dst_red};

	// Select both factors per channel
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			fs_vec[ch] = pick_factor(cfg.src_factor, s_vec[ch], s_vec[ALPHA_CH],
				d_vec[ch], d_vec[ALPHA_CH]);
			fd_vec[ch] = pick_factor(cfg.dst_factor, s_vec[ch], s_vec[ALPHA_CH],
				d_vec[ch], d_vec[ALPHA_CH]);
		end
	end

	// Take an item when this stage is empty or drains this cycle
	assign pix_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			src_s1 <= s_vec;
			dst_s1 <= d_vec;
			fs_s1  <= fs_vec;
			fd_s1  <= fd_vec;
		end
	end

endmodule

### design/cbu_mul_stage.sv
module cbu_mul_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	output logic               ready_s1,
	input  cbu_pkg::chan_vec_t src_s1,
	input  cbu_pkg::chan_vec_t dst_s1,
	input  cbu_pkg::chan_vec_t fs_s1,
	input  cbu_pkg::chan_vec_t fd_s1,
	output logic               valid_s3,
	input  logic               ready_s3,
	output cbu_pkg::chan_vec_t ps_s3,
	output cbu_pkg::chan_vec_t pd_s3,
	output cbu_pkg::cbu_occ_t  occ
);
	import cbu_pkg::*;

	logic      valid_s2;
	logic      ready_s2;
	prod_vec_t ps_s2;
	prod_vec_t pd_s2;

	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s1 = !valid_s2 || ready_s2;
	assign occ      = '{valid_s2: valid_s2, valid_s3: valid_s3};

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s2) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Raw 8x8 products
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				ps_s2[ch] <= PROD_W'(src_s1[ch]) * PROD_W'(fs_s1[ch]);
				pd_s2[ch] <= PROD_W'(dst_s1[ch]) * PROD_W'(fd_s1[ch]);
			end
		end
	end

	// Rounded scale back to unorm
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s2) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				ps_s3[ch] <= div255_round(ps_s2[ch]);
				pd_s3[ch] <= div255_round(pd_s2[ch]);
			end
		end
	end

endmodule

### design/cbu_combine_stage.sv
module cbu_combine_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s3,
	output logic                      ready_s3,
	input  cbu_pkg::chan_vec_t        ps_s3,
	input  cbu_pkg::chan_vec_t        pd_s3,
	input  logic [cbu_pkg::EQ_W-1:0]  equation,
	output logic                      blend_valid,
	input  logic                      blend_ready,
	output cbu_pkg::cbu_out_t         blend
);
	import cbu_pkg::*;

	chan_vec_t       res;
	logic [CH_W:0]   sum;
	chan_vec_t       res_s4;

	// Apply the equation per channel
	always_comb begin
		sum = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum = {1'b0, ps_s3[ch]} + {1'b0, pd_s3[ch]};
			case (equation)
				EQ_SUB:  res[ch] = (ps_s3[ch] > pd_s3[ch]) ? ps_s3[ch] - pd_s3[ch] : '0;
				EQ_RSUB: res[ch] = (pd_s3[ch] > ps_s3[ch]) ? pd_s3[ch] - ps_s3[ch] : '0;
				EQ_MIN:  res[ch] = (ps_s3[ch] < pd_s3[ch]) ? ps_s3[ch] : pd_s3[ch];
				EQ_MAX:  res[ch] = (ps_s3[ch] > pd_s3[ch]) ? ps_s3[ch] : pd_s3[ch];
				default: res[ch] = sum[CH_W] ? UNORM_ONE : sum[CH_W-1:0];
			endcase
		end
	end

	// Output register parts the pipeline from the receiver
	assign ready_s3 = !blend_valid || blend_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_valid <= 1'b0;
		end else if (ready_s3) begin
			blend_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			res_s4 <= res;
		end
	end

	assign blend = '{out_red: res_s4[0], out_green: res_s4[1],
		out_blue: res_s4[2], out_alpha: res_s4[ALPHA_CH]};

endmodule

### design/color_blend_unit.sv
// Color blend unit: blends one RGBA8 source/destination pixel pair per item.
// Input channel pix (pix_valid/pix_ready) carries both pixels; output
// channel blend (blend_valid/blend_ready) carries the blended RGBA pixel.
// Each side is scaled per channel by its factor (rounded a*b/255), then the
// two are combined by the equation (add saturates, subtracts clamp at 0).
// Configuration: cfg_we/cfg_index/cfg_data write equation (0), source
// factor (1) and destination factor (2); write only while no item is in
// flight. Writes to index 3 are ignored.
// Pipeline: four register stages lie between acceptance and blend_valid:
// factor select, multiply, divide by 255, combine.
// Throughput: one item per cycle while blend_ready is high; each stage
// has a valid bit and takes an item if empty or draining in the same cycle.
// Stall: with blend_ready low the result holds in the output register and
// up to three more items queue in the earlier stages; pix_ready drops only
// once all four stages are full.
// Reset: arst_n clears all valid bits and all three registers to zero
// (add, zero factors), so results before configuration are zero.
module color_blend_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  cbu_pkg::cbu_in_t               pix,
	output logic                           blend_valid,
	input  logic                           blend_ready,
	output cbu_pkg::cbu_out_t              blend,
	input  logic                           cfg_we,
	input  logic [cbu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cbu_pkg::*;

`include "color_blend_unit_defines.svh"

	cbu_cfg_t  cfg_q;
	logic      valid_s1;
	logic      ready_s1;
	chan_vec_t src_s1;
	chan_vec_t dst_s1;
	chan_vec_t fs_s1;
	chan_vec_t fd_s1;
	logic      valid_s3;
	logic      ready_s3;
	chan_vec_t ps_s3;
	chan_vec_t pd_s3;
	cbu_occ_t  occ;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EQUATION:   cfg_q.equation   <= cfg_data[EQ_W-1:0];
				REG_SRC_FACTOR: cfg_q.src_factor <= cfg_data[FACTOR_W-1:0];
				REG_DST_FACTOR: cfg_q.dst_factor <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	cbu_factor_stage u_factor (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.src_s1    (src_s1),
		.dst_s1    (dst_s1),
		.fs_s1     (fs_s1),
		.fd_s1     (fd_s1)
	);

	cbu_mul_stage u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.src_s1   (src_s1),
		.dst_s1   (dst_s1),
		.fs_s1    (fs_s1),
		.fd_s1    (fd_s1),
		.valid_s3 (valid_s3),
		.ready_s3 (ready_s3),
		.ps_s3    (ps_s3),
		.pd_s3    (pd_s3),
		.occ      (occ)
	);

	cbu_combine_stage u_combine (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.ready_s3    (ready_s3),
		.ps_s3       (ps_s3),
		.pd_s3       (pd_s3),
		.equation    (cfg_q.equation),
		.blend_valid (blend_valid),
		.blend_ready (blend_ready),
		.blend       (blend)
	);

	// An empty output register must never block the input
	`CBU_ASSERT_NOW(a_ready_when_out_empty, !blend_valid, pix_ready, "pix_ready low with empty output")

	// Input stalls only when every stage holds an item and the output waits
	`CBU_ASSERT_NOW(a_stall_only_full, !pix_ready, (blend_valid && !blend_ready && valid_s1 && occ.valid_s2 && occ.valid_s3), "input stalled with a free stage")

	// A waiting result leaves only when taken
	`CBU_ASSERT_NEXT(a_result_kept, (blend_valid && !blend_ready), blend_valid, "result dropped while stalled")

endmodule

### bench/blend_result_check.sv
`timescale 1ns / 1ps

// Watch both channels of the blend unit, predict each blended pixel and
// compare it with what comes out.
module blend_result_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	input  logic                           pix_ready,
	input  cbu_pkg::cbu_in_t               pix,
	input  logic                           blend_valid,
	input  logic                           blend_ready,
	input  cbu_pkg::cbu_out_t              blend,
	input  logic                           cfg_we,
	input  logic [cbu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatch_count,
	output int                             pending_results
);
	import cbu_pkg::*;

	cbu_cfg_t blend_regs = '0;
	cbu_out_t expected_pixels[$];
	int       mismatches = 0;
	int       waiting = 0;

	assign mismatch_count  = mismatches;
	assign pending_results = waiting;

	// Rounded unorm product a*b/255
	function automatic int unorm_scale(input int a, input int b);
		return (a * b + 127) / 255;
	endfunction

	// Factor for one channel; alpha factors read channel ALPHA_CH of either pixel
	function automatic int channel_factor(
		input logic [FACTOR_W-1:0] code,
		input chan_vec_t           s,
		input chan_vec_t           d,
		input int                  ch
	);
		case (code)
			F_ONE:           return UNORM_ONE;
			F_SRC_COLOR:     return s[ch];
			F_DST_COLOR:     return d[ch];
			F_SRC_ALPHA:     return s[ALPHA_CH];
			F_DST_ALPHA:     return d[ALPHA_CH];
			F_INV_SRC_COLOR: return UNORM_ONE - s[ch];
			F_INV_DST_COLOR: return UNORM_ONE - d[ch];
			F_INV_SRC_ALPHA: return UNORM_ONE - s[ALPHA_CH];
			F_INV_DST_ALPHA: return UNORM_ONE - d[ALPHA_CH];
			default:         return 0;
		endcase
	endfunction

	// Scale both sides per channel, then combine by the equation
	function automatic cbu_out_t blend_pixel(input cbu_in_t px, input cbu_cfg_t regs);
		chan_vec_t s;
		chan_vec_t d;
		chan_vec_t o;
		int        ps;
		int        pd;
		int        mix;
		s = {px.src_alpha, px.src_blue, px.src_green, px.src_red};
		d = {px.dst_alpha, px.dst_blue, px.dst_green, px.dst_red};
		for (int ch = 0; ch < NUM_CH; ch++) begin
			ps = unorm_scale(s[ch], channel_factor(regs.src_factor, s, d, ch));
			pd = unorm_scale(d[ch], channel_factor(regs.dst_factor, s, d, ch));
			case (regs.equation)
				EQ_SUB:  mix = (ps > pd) ? ps - pd : 0;
				EQ_RSUB: mix = (pd > ps) ? pd - ps : 0;
				EQ_MIN:  mix = (ps < pd) ? ps : pd;
				EQ_MAX:  mix = (ps > pd) ? ps : pd;
				default: mix = (ps + pd > 255) ? 255 : ps + pd;
			endcase
			o[ch] = CH_W'(mix);
		end
		return cbu_out_t'({o[0], o[1], o[2], o[3]});
	endfunction

	task automatic note_failure(input string what, input cbu_out_t want, input cbu_out_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t %s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
				$realtime, what, want.out_red, want.out_green, want.out_blue, want.out_alpha,
				got.out_red, got.out_green, got.out_blue, got.out_alpha);
		end
	endtask

	// Check results, queue predictions, then track register writes
	always @(posedge clk or negedge arst_n) begin
		cbu_out_t want;
		if (!arst_n) begin
			blend_regs = '0;
			expected_pixels.delete();
		end else begin
			if (blend_valid && blend_ready) begin
				if (expected_pixels.size() == 0) begin
					note_failure("blended item with nothing expected", '0, blend);
				end else begin
					want = expected_pixels.pop_front();
					if (blend.out_red !== want.out_red || blend.out_green !== want.out_green ||
					    blend.out_blue !== want.out_blue || blend.out_alpha !== want.out_alpha) begin
						note_failure("blended item mismatch", want, blend);
					end
				end
			end
			if (pix_valid && pix_ready) begin
				expected_pixels.push_back(blend_pixel(pix, blend_regs));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_EQUATION:   blend_regs.equation   = cfg_data[EQ_W-1:0];
					REG_SRC_FACTOR: blend_regs.src_factor = cfg_data[FACTOR_W-1:0];
					REG_DST_FACTOR: blend_regs.dst_factor = cfg_data[FACTOR_W-1:0];
					default: ;
				endcase
			end
		end
		waiting = expected_pixels.size();
	end

endmodule

### bench/tb_color_blend_unit.sv
`timescale 1ns / 1ps

module tb_color_blend_unit;
	import cbu_pkg::*;

	localparam int RESET_CYCLES  = 10;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_BLOCKS = 14;
	localparam int BLOCK_ITEMS   = 100;
	localparam int BURST_ITEMS   = 60;
	localparam int DRAIN_CYCLES  = 8;

	// Codes with no name in the package
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam logic [EQ_W-1:0]      EQ_UNUSED   = 3'd7;
	localparam logic [FACTOR_W-1:0]  F_UNUSED_LO = 4'd10;
	localparam logic [FACTOR_W-1:0]  F_UNUSED_HI = 4'd15;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	cbu_in_t               pix = '0;
	logic                  blend_valid;
	logic                  blend_ready = 1'b0;
	cbu_out_t              blend;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatch_count;
	int pending_results;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #4 clk = ~clk;

	color_blend_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.blend_valid(blend_valid),
		.blend_ready(blend_ready),
		.blend      (blend),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	blend_result_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_ready      (pix_ready),
		.pix            (pix),
		.blend_valid    (blend_valid),
		.blend_ready    (blend_ready),
		.blend          (blend),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_results(pending_results)
	);

	// Stall the result side at random; hold it off once for a long stretch
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				blend_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				blend_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (blend_valid && blend_ready)) quiet = 0;
			else quiet++;
		end
		$display("[color_blend_unit] ERROR");
		$finish;
	end

	// Lean toward the ends of the range
	function automatic logic [CH_W-1:0] channel_value();
		case ($urandom_range(7))
			0:       return '0;
			1:       return UNORM_ONE;
			2:       return CH_W'($urandom_range(3));
			3:       return UNORM_ONE - CH_W'($urandom_range(3));
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	function automatic cbu_in_t random_pixel();
		cbu_in_t px;
		px.src_red   = channel_value();
		px.src_green = channel_value();
		px.src_blue  = channel_value();
		px.src_alpha = channel_value();
		px.dst_red   = channel_value();
		px.dst_green = channel_value();
		px.dst_blue  = channel_value();
		px.dst_alpha = channel_value();
		return px;
	endfunction

	function automatic cbu_in_t pixel_of(input logic [CH_W-1:0] sr, sg, sb, sa, dr, dg, db, da);
		return cbu_in_t'({sr, sg, sb, sa, dr, dg, db, da});
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_factor();
		if ($urandom_range(4) == 0) return CFG_DATA_W'($urandom_range(15));
		return CFG_DATA_W'($urandom_range(F_INV_DST_ALPHA));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_equation();
		if ($urandom_range(4) == 0) return CFG_DATA_W'($urandom_range(15));
		return CFG_DATA_W'($urandom_range(EQ_MAX));
	endfunction

	// Offer one item after a random gap; return at the edge that takes it
	task automatic drive_pixel(input cbu_in_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			pix <= random_pixel();
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= px;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		pix_valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Write all three registers back to back, optionally poke the spare index
	task automatic program_regs(input logic [CFG_DATA_W-1:0] eq_d, sf_d, df_d,
			input bit poke_spare);
		cfg_we <= 1'b1;
		cfg_index <= REG_EQUATION;
		cfg_data <= eq_d;
		@(posedge clk);
		cfg_index <= REG_SRC_FACTOR;
		cfg_data <= sf_d;
		@(posedge clk);
		cfg_index <= REG_DST_FACTOR;
		cfg_data <= df_d;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= CFG_DATA_W'($urandom_range(15));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_case(input logic [CFG_DATA_W-1:0] eq_d, sf_d, df_d,
			input bit poke_spare, input cbu_in_t first, input cbu_in_t second);
		program_regs(eq_d, sf_d, df_d, poke_spare);
		drive_pixel(first);
		drive_pixel(second);
		drain_results();
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] eq_d;
		logic [CFG_DATA_W-1:0] sf_d;
		logic [CFG_DATA_W-1:0] df_d;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings blend everything to zero
		drive_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		drain_results();

		// Add saturating at full scale
		directed_case(CFG_DATA_W'(EQ_ADD), F_ONE, F_ONE, 1'b0,
			pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			pixel_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// Classic source-over
		directed_case(CFG_DATA_W'(EQ_ADD), F_SRC_ALPHA, F_INV_SRC_ALPHA, 1'b0,
			pixel_of(8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30, 8'hFF),
			pixel_of(8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFE));
		// Subtract, clamping at zero on some channels
		directed_case(CFG_DATA_W'(EQ_SUB), F_SRC_COLOR, F_DST_COLOR, 1'b0,
			pixel_of(8'd10, 8'd200, 8'hFF, 8'h00, 8'hFF, 8'd100, 8'hFF, 8'h00),
			pixel_of(8'd128, 8'd127, 8'h01, 8'hFE, 8'd127, 8'd128, 8'hFE, 8'h01));
		directed_case(CFG_DATA_W'(EQ_RSUB), F_DST_ALPHA, F_INV_DST_ALPHA, 1'b0,
			pixel_of(8'hFF, 8'd64, 8'h00, 8'd77, 8'h00, 8'd192, 8'hFF, 8'd180),
			pixel_of(8'd1, 8'd2, 8'd3, 8'hFF, 8'd250, 8'd251, 8'd252, 8'h00));
		// Inverse color factors apply to alpha as well
		directed_case(CFG_DATA_W'(EQ_MIN), F_INV_SRC_COLOR, F_INV_DST_COLOR, 1'b0,
			pixel_of(8'h00, 8'hFF, 8'd128, 8'd40, 8'hFF, 8'h00, 8'd127, 8'd220),
			pixel_of(8'd90, 8'd91, 8'd92, 8'd93, 8'd90, 8'd91, 8'd92, 8'd93));
		directed_case(CFG_DATA_W'(EQ_MAX), F_DST_COLOR, F_INV_DST_ALPHA, 1'b0,
			pixel_of(8'd33, 8'hFF, 8'h00, 8'd200, 8'd180, 8'h00, 8'hFF, 8'd60),
			pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
		// Unused equation code acts as add, unused factor codes give zero
		directed_case(CFG_DATA_W'(EQ_UNUSED), F_UNUSED_HI, F_ONE, 1'b0,
			pixel_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd12, 8'd34, 8'd56, 8'd78),
			pixel_of(8'd200, 8'd1, 8'd99, 8'd0, 8'hFF, 8'd0, 8'd128, 8'hFF));
		// Write data wider than the equation register keeps its low bits only
		directed_case({1'b1, EQ_MAX}, F_INV_SRC_ALPHA, F_UNUSED_LO, 1'b1,
			pixel_of(8'd150, 8'd60, 8'd255, 8'd100, 8'd240, 8'd250, 8'd0, 8'd10),
			pixel_of(8'd0, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

		// Random blocks, each with its own settings and idling mode
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk)
				0: begin
					eq_d = CFG_DATA_W'(EQ_ADD); sf_d = F_ZERO; df_d = F_ZERO;
				end
				1: begin
					eq_d = CFG_DATA_W'(EQ_MAX); sf_d = F_INV_DST_ALPHA; df_d = F_INV_DST_ALPHA;
				end
				2: begin
					eq_d = {1'b1, EQ_UNUSED}; sf_d = F_UNUSED_HI; df_d = F_UNUSED_HI;
				end
				3: begin
					eq_d = CFG_DATA_W'(EQ_SUB); sf_d = F_ONE; df_d = F_INV_SRC_COLOR;
				end
				default: begin
					eq_d = random_equation(); sf_d = random_factor(); df_d = random_factor();
				end
			endcase
			case (blk % 4)
				0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1:       begin src_idle_pct = 86; sink_stall_pct = 0;  end
				2:       begin src_idle_pct = 0;  sink_stall_pct = 86; end
				default: begin src_idle_pct = 31; sink_stall_pct = 31; end
			endcase
			program_regs(eq_d, sf_d, df_d, 1'($urandom_range(1)));
			for (int i = 0; i < BLOCK_ITEMS; i++) drive_pixel(random_pixel());
			drain_results();
		end

		// Fill the pipeline against a long output hold-off
		src_idle_pct = 0;
		sink_stall_pct = 0;
		program_regs(random_equation(), random_factor(), random_factor(), 1'b0);
		hold_req = 1'b1;
		for (int i = 0; i < BURST_ITEMS; i++) drive_pixel(random_pixel());
		drain_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[color_blend_unit] OK");
		end else begin
			$display("[color_blend_unit] ERROR");
		end
		$finish;
	end

endmodule
